@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// A checker must provide clk and rst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define POD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("page directory assertion failed");

// Checked in every cycle, reset included.
`define POD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("page directory assertion failed");

`endif

@@ hw/rtl/pod_pkg.sv @@
// Package of the page ownership directory: sizes, codes and beat types.
// Used by every module of the block but pod_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pod_pkg;

  localparam int MAX_PAGES   = 128;
  localparam int MAX_COPIES  = 32;
  localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
  localparam int COPY_IDX_W  = $clog2(MAX_COPIES);
  localparam int COUNT_W     = $clog2(MAX_COPIES + 1);
  localparam int COPY_ADDR_W = PAGE_IDX_W + COPY_IDX_W;
  localparam int HOST_W      = 32;
  localparam int PORT_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] MAX_PAGES_B = 8'(MAX_PAGES);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_PORT_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT     = 2'd2;

  localparam logic [PORT_W-1:0] RST_SERVER_PORT    = 16'd0;
  localparam logic [PORT_W-1:0] RST_COPY_PORT_BASE = 16'd2000;
  localparam logic [7:0]        RST_PAGE_COUNT     = 8'd128;

  // Request modes.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Reply kinds.
  localparam logic [2:0] KIND_READ_FIRST = 3'd0;
  localparam logic [2:0] KIND_READ_OWNER = 3'd1;
  localparam logic [2:0] KIND_WRITE_GRANT = 3'd2;
  localparam logic [2:0] KIND_INVALIDATE = 3'd3;
  localparam logic [2:0] KIND_WRITE_OWNER = 3'd4;
  localparam logic [2:0] KIND_BAD_PAGE   = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [7:0]        page_number;
    logic [HOST_W-1:0] requester_host;
  } pod_in_t;

  typedef struct packed {
    logic [2:0]        reply_kind;
    logic [HOST_W-1:0] peer_host;
    logic [PORT_W-1:0] port_first;
    logic [PORT_W-1:0] port_second;
    logic              copy_dropped;
    logic              last;
  } pod_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic cap;         // capture the accepted request
    logic dec;         // emit the single reply of a request
    logic walk_start;  // client-owned write: start the invalidate walk
    logic inv;         // emit one invalidate beat
    logic fin;         // emit the closing write-from-owner beat
  } pod_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk;        // valid write to a client-owned page
    logic cnt_zero;    // copy set of the page is empty
    logic walk_last;   // current invalidate is the final one
    logic out_free;    // output register can take a beat
  } pod_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/page_ownership_directory_core.sv @@
// Page ownership directory: one request beat in, one or more reply beats out.
// Input beat (in_valid/in_stall, in_data): mode, 1-based page number and
// requester host. Output beat (out_valid/out_stall, out_data): reply kind,
// peer host, two ports, a copy-dropped flag and last on the request's final
// beat. Configuration (cfg_we, cfg_index, cfg_wdata) writes server port,
// copy port base and page count. The user must write it only while no
// request is in flight; the block itself does not enforce this.
// A single-reply request is accepted, its tables are read in state S_RD
// and its reply is registered in state S_DEC once the output is free.
// A write to a client-owned page starts the walk, then walks its copy set
// through the copy RAM, one invalidate beat per cycle while the receiver
// does not stall, then closes with the write-from-owner beat.
// in_stall is low only between requests; a reply waiting in the output
// register does not block the next request from being taken. When the
// receiver stalls, the output beat holds and the walk pauses.
// Reset returns every page to the server, clears the copy-count flags of all
// pages at once and restores the configuration; the block takes requests
// right after reset.
// Depends on pod_pkg, pod_ctrl, pod_datapath and pod_ram.
`timescale 1ns / 1ps
`default_nettype none

module page_ownership_directory_core
  import pod_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pod_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pod_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  pod_cmd_t  cmd;
  pod_stat_t st;

  pod_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pod_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pod_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/pod_ctrl.sv @@
// Sequencer of the page directory: steps one request through lookup,
// decision and the invalidate walk. Depends on pod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pod_ctrl
  import pod_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pod_stat_t st,
  output pod_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_INV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // Table reads are issued here and land in the next cycle.
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (st.walk) begin
          cmd.walk_start = 1'b1;
          state_nxt      = st.cnt_zero ? S_FIN : S_INV;
        end else if (st.out_free) begin
          cmd.dec   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INV: begin
        if (st.out_free) begin
          cmd.inv = 1'b1;
          if (st.walk_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pod_datapath.sv @@
// Datapath of the page directory: configuration, page tables, port
// counters and the output register. Depends on pod_pkg and pod_ram.
`timescale 1ns / 1ps
`default_nettype none

module pod_datapath
  import pod_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire pod_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pod_out_t                   out_data,
  input  wire pod_cmd_t              cmd,
  output pod_stat_t                  st
);

  logic [PORT_W-1:0] server_port_r;
  logic [PORT_W-1:0] copy_port_base_r;
  logic [7:0]        page_count_r;

  pod_in_t           req_r;
  logic [PORT_W-1:0] ooff_r;
  logic [PORT_W-1:0] ooff_nxt;
  logic [PORT_W-1:0] coff_r;
  logic [PORT_W-1:0] nport_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] walk_r;
  logic [COUNT_W-1:0] walk_nxt;

  // Ownership and count-valid flags, one per page; reset sets every ownership flag and clears every count-valid flag.
  logic [MAX_PAGES-1:0] owned_r;
  logic [MAX_PAGES-1:0] cnt_valid_r;

  logic                  out_valid_r;
  pod_out_t              out_r;
  pod_out_t              out_nxt;
  logic                  out_load;

  logic [PAGE_IDX_W-1:0] idx;
  logic                  bad;
  logic                  owned;
  logic [COUNT_W-1:0]    cnt_rd;
  logic [COUNT_W-1:0]    cnt_eff;
  logic                  full;
  logic [PORT_W-1:0]     cport;
  logic [PORT_W-1:0]     nport;

  logic [HOST_W+PORT_W-1:0] owner_rd;
  logic [HOST_W+PORT_W-1:0] copy_rd;
  logic                     owner_we;
  logic                     cnt_we;
  logic                     copy_we;
  logic [COPY_ADDR_W-1:0]   copy_waddr;
  logic [COPY_ADDR_W-1:0]   copy_raddr;

  assign idx     = PAGE_IDX_W'(req_r.page_number - 8'd1);
  assign bad     = (req_r.page_number == 8'd0) || (req_r.page_number > page_count_r) ||
                   (req_r.page_number > MAX_PAGES_B);
  assign owned   = owned_r[idx];
  assign cnt_eff = cnt_valid_r[idx] ? cnt_rd : '0;
  assign full    = (cnt_eff >= COUNT_W'(MAX_COPIES));
  assign cport   = copy_port_base_r + coff_r;
  assign nport   = server_port_r + ooff_r + 16'd1;

  assign st.walk      = !bad && (req_r.mode == MODE_WRITE) && !owned;
  assign st.cnt_zero  = (cnt_eff == '0);
  assign st.walk_last = ((walk_r + 1'b1) == cnt_r);
  assign st.out_free  = !out_valid_r || !out_stall;

  // The copy read address follows the next walk position, so the read data
  // always belongs to the current position.
  always_comb begin
    walk_nxt = walk_r;
    if (cmd.walk_start) begin
      walk_nxt = '0;
    end else if (cmd.inv) begin
      walk_nxt = walk_r + 1'b1;
    end
  end

  assign copy_raddr = {idx, walk_nxt[COPY_IDX_W-1:0]};
  assign copy_waddr = {idx, cnt_eff[COPY_IDX_W-1:0]};

  assign copy_we  = cmd.dec && !bad && (req_r.mode == MODE_READ) && owned && !full;
  assign cnt_we   = copy_we;
  assign owner_we = (cmd.dec && !bad && (req_r.mode == MODE_WRITE) && owned) || cmd.fin;

  pod_ram #(.WIDTH(HOST_W + PORT_W), .DEPTH(MAX_PAGES)) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (idx),
    .wdata ({req_r.requester_host, cmd.fin ? nport_r : nport}),
    .raddr (idx),
    .rdata (owner_rd)
  );

  pod_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_PAGES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx),
    .wdata (cnt_eff + 1'b1),
    .raddr (idx),
    .rdata (cnt_rd)
  );

  pod_ram #(.WIDTH(HOST_W + PORT_W), .DEPTH(MAX_PAGES * MAX_COPIES)) u_copy_ram (
    .clk   (clk),
    .we    (copy_we),
    .waddr (copy_waddr),
    .wdata ({req_r.requester_host, cport}),
    .raddr (copy_raddr),
    .rdata (copy_rd)
  );

  always_comb begin
    out_nxt  = '0;
    out_load = cmd.dec || cmd.inv || cmd.fin;
    ooff_nxt = ooff_r;
    if (cmd.dec && !bad && (req_r.mode == MODE_WRITE)) begin
      ooff_nxt = ooff_r + 16'd1;
    end
    if (cmd.walk_start) begin
      ooff_nxt = ooff_r + 16'd1;
    end
    out_nxt.last = 1'b1;
    if (cmd.inv) begin
      out_nxt.reply_kind = KIND_INVALIDATE;
      out_nxt.peer_host  = copy_rd[HOST_W+PORT_W-1:PORT_W];
      out_nxt.port_first = copy_rd[PORT_W-1:0];
      out_nxt.last       = 1'b0;
    end else if (cmd.fin) begin
      out_nxt.reply_kind  = KIND_WRITE_OWNER;
      out_nxt.peer_host   = owner_rd[HOST_W+PORT_W-1:PORT_W];
      out_nxt.port_first  = nport_r;
      out_nxt.port_second = owner_rd[PORT_W-1:0];
    end else if (bad) begin
      out_nxt.reply_kind = KIND_BAD_PAGE;
    end else if (req_r.mode == MODE_READ) begin
      out_nxt.port_second = cport;
      if (owned) begin
        out_nxt.reply_kind   = KIND_READ_FIRST;
        out_nxt.peer_host    = req_r.requester_host;
        out_nxt.copy_dropped = full;
      end else begin
        out_nxt.reply_kind = KIND_READ_OWNER;
        out_nxt.peer_host  = owner_rd[HOST_W+PORT_W-1:PORT_W];
        out_nxt.port_first = owner_rd[PORT_W-1:0];
      end
    end else begin
      out_nxt.reply_kind = KIND_WRITE_GRANT;
      out_nxt.peer_host  = req_r.requester_host;
      out_nxt.port_first = nport;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r    <= RST_SERVER_PORT;
      copy_port_base_r <= RST_COPY_PORT_BASE;
      page_count_r     <= RST_PAGE_COUNT;
      ooff_r           <= '0;
      coff_r           <= '0;
      owned_r          <= '1;
      cnt_valid_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SERVER_PORT:    server_port_r    <= cfg_wdata;
          CFG_COPY_PORT_BASE: copy_port_base_r <= cfg_wdata;
          CFG_PAGE_COUNT:     page_count_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      ooff_r <= ooff_nxt;
      if (cmd.dec && !bad && (req_r.mode == MODE_READ)) begin
        coff_r <= coff_r + 16'd1;
      end
      if (cmd.dec && !bad && (req_r.mode == MODE_WRITE) && owned) begin
        owned_r[idx] <= 1'b0;
      end
      if (cnt_we) begin
        cnt_valid_r[idx] <= 1'b1;
      end else if (cmd.fin) begin
        // An invalid entry reads as an empty copy set.
        cnt_valid_r[idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_data;
    end
    if (cmd.walk_start) begin
      nport_r <= nport;
      cnt_r   <= cnt_eff;
    end
    walk_r <= walk_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ hw/rtl/pod_checker.sv @@
// Port-level checks of the page directory, bound to the top level.
// Depends on pod_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pod_checker
  import pod_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire pod_out_t out_data
);

  `POD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)
  `POD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
  `POD_ASSERT(a_inv_not_last, out_valid && (out_data.reply_kind == KIND_INVALIDATE) |-> !out_data.last)
  `POD_ASSERT(a_other_last, out_valid && (out_data.reply_kind != KIND_INVALIDATE) |-> out_data.last)
  `POD_ASSERT(a_drop_kind, out_valid && out_data.copy_dropped |-> out_data.reply_kind == KIND_READ_FIRST)

endmodule

bind page_ownership_directory_core pod_checker u_pod_checker (.*);

`default_nettype wire
